[hdl/pxbp_pkg.sv]
// pxbp_pkg: shared types and constants for the pixel threshold bit packer
// holds channel payload structs, mode and register index codes
// no dependencies
package pxbp_pkg;

    localparam int unsigned CHAN_WIDTH      = 8;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 8;

    // floor(x / 3) == (x * 683) >> 11 for every sum of three 8-bit channels
    localparam int unsigned MEAN_RECIP = 683;
    localparam int unsigned MEAN_SHIFT = 11;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_SINGLE = 2'd0;
    localparam mode_t MODE_MEAN   = 2'd1;
    localparam mode_t MODE_ALPHA  = 2'd2;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    localparam cfg_index_t CFG_THRESHOLD    = 2'd0;
    localparam cfg_index_t CFG_CHANNEL_MODE = 2'd1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd127;
    localparam mode_t      MODE_RESET      = MODE_SINGLE;

    typedef struct packed {
        logic [7:0] chan_zero;
        logic [7:0] chan_one;
        logic [7:0] chan_two;
        logic [7:0] chan_alpha;
        logic       pixel_last;
    } pixel_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic [3:0] bits_valid;
        logic       byte_last;
    } packed_t;

    // one binarized pixel between the threshold stage and the packer
    typedef struct packed {
        logic pixel_bit;
        logic pixel_last;
    } pixel_bit_t;

endpackage

[hdl/pxbp_binarize.sv]
// pxbp_binarize: registered pixel stage that reduces a pixel to one bit
// computes the channel mean at the input, scales and thresholds after the register
// depends on pxbp_pkg
module pxbp_binarize (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          threshold,
    input  pxbp_pkg::mode_t     channel_mode,
    input  logic                in_valid,
    output logic                in_ready,
    input  pxbp_pkg::pixel_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pxbp_pkg::pixel_bit_t out_data
);
    import pxbp_pkg::*;

    logic [9:0]  chan_sum;
    logic [20:0] mean_prod;
    logic [7:0]  mean_in;

    logic        valid_reg;
    logic [7:0]  mean_reg;
    logic [7:0]  chan_zero_reg;
    logic [7:0]  alpha_reg;
    logic        last_reg;

    logic [15:0] scaled;
    logic [8:0]  thresh_plus;
    logic [16:0] alpha_limit;
    logic        bit_value;
    logic        load;

    // mean of the three color channels by reciprocal multiply
    assign chan_sum  = 10'(in_data.chan_zero) + 10'(in_data.chan_one)
                     + 10'(in_data.chan_two);
    assign mean_prod = 21'(chan_sum) * 21'(MEAN_RECIP);
    assign mean_in   = mean_prod[MEAN_SHIFT +: 8];

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mean_reg      <= mean_in;
            chan_zero_reg <= in_data.chan_zero;
            alpha_reg     <= in_data.chan_alpha;
            last_reg      <= in_data.pixel_last;
        end
    end

    // floor(m * a / 255) > t  <=>  m * a >= 255 * (t + 1)
    assign scaled      = 16'(mean_reg) * 16'(alpha_reg);
    assign thresh_plus = 9'(threshold) + 9'd1;
    assign alpha_limit = {thresh_plus, 8'd0} - 17'(thresh_plus);

    always_comb begin
        case (channel_mode)
            MODE_MEAN:  bit_value = mean_reg > threshold;
            MODE_ALPHA: bit_value = 17'(scaled) >= alpha_limit;
            default:    bit_value = chan_zero_reg > threshold;
        endcase
    end

    assign out_valid           = valid_reg;
    assign out_data.pixel_bit  = bit_value;
    assign out_data.pixel_last = last_reg;

endmodule

[hdl/pixel_threshold_bit_packer.sv]
// pixel_threshold_bit_packer: top level of the pixel binarizer and bit packer
// instantiates pxbp_binarize, holds configuration, packing state and result register
// depends on pxbp_pkg
//
// usage
//   s_ channel: one pixel per transfer (four 8-bit channels and an end-of-image flag)
//   m_ channel: one packed byte per transfer, earliest pixel in bit zero, with the
//     number of pixel bits it holds and an end-of-image flag
//   cfg channel: index 0 writes the threshold, index 1 the channel mode; other
//     indexes are ignored; always ready, write only while no pixel is in flight
//   throughput is one pixel per clock while the m_ side takes bytes, set by the
//   two-register pixel path (pixel register, then result register); a byte leaves
//   every eighth pixel or at the image's last pixel
//   the pixel that closes the byte first loads the pixel register, then the result
//   register, so m_valid rises when the result register loads the byte
//   a stalled m_ side holds the finished byte in the result register while the
//   pixel register still takes pixels that do not close a byte; s_ready drops
//   only when a closing pixel waits behind the held byte
//   reset (aresetn low, synchronous) empties both registers, clears the partial
//   byte and returns threshold to 127 and channel mode to single channel
module pixel_threshold_bit_packer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pxbp_pkg::pixel_t      s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pxbp_pkg::packed_t     m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  pxbp_pkg::cfg_index_t  cfg_index,
    input  logic [7:0]            cfg_data
);
    import pxbp_pkg::*;

    // configuration registers
    logic [7:0] threshold_reg;
    mode_t      mode_reg;

    // binarized pixel from the threshold stage
    logic       bit_valid;
    logic       bit_ready;
    pixel_bit_t bit_data;

    // packing state: bits gathered so far and their count
    logic [6:0] acc_reg;
    logic [6:0] acc_next;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;

    // result register
    logic       m_valid_reg;
    logic       m_valid_next;
    packed_t    m_data_reg;
    packed_t    m_data_next;

    logic [7:0] gathered;
    logic       closes_byte;
    logic       out_free;
    logic       bit_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            mode_reg      <= MODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_THRESHOLD:    threshold_reg <= cfg_data;
                CFG_CHANNEL_MODE: mode_reg      <= mode_t'(cfg_data[1:0]);
                default:          ;
            endcase
        end
    end

    pxbp_binarize u_binarize (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .threshold    (threshold_reg),
        .channel_mode (mode_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_data      (s_data),
        .out_valid    (bit_valid),
        .out_ready    (bit_ready),
        .out_data     (bit_data)
    );

    // a pixel closes its byte when it is the eighth bit or the last of the image
    assign closes_byte = (pos_reg == 3'd7) || bit_data.pixel_last;
    assign out_free    = !m_valid_reg || m_ready;
    // pixels that only add to the partial byte never wait on the m_ side
    assign bit_ready   = !closes_byte || out_free;
    assign bit_take    = bit_valid && bit_ready;

    assign gathered = {1'b0, acc_reg} | (8'(bit_data.pixel_bit) << pos_reg);

    always_comb begin
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (bit_take) begin
            if (closes_byte) begin
                m_valid_next            = 1'b1;
                m_data_next.packed_byte = gathered;
                m_data_next.bits_valid  = 4'(pos_reg) + 4'd1;
                m_data_next.byte_last   = bit_data.pixel_last;
                acc_next                = 7'd0;
                pos_next                = 3'd0;
            end else begin
                acc_next = gathered[6:0];
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= 7'd0;
            pos_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload only changes when a new byte is loaded
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a byte that does not close the image is always full
    a_mid_byte_full : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_last |-> m_data.bits_valid == 4'd8)
        else $error("non-final byte with fewer than eight bits");

    // bits above the valid count are zero
    a_upper_bits_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.packed_byte >> m_data.bits_valid) == 8'd0)
        else $error("packed byte carries bits above its count");

    // the partial byte holds no bit at or above its fill position
    a_acc_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg >> pos_reg) == 7'd0)
        else $error("partial byte has stray bits");

    // the closing pixel of a byte is taken only when the result register can load
    a_close_loads : assert property (@(posedge aclk) disable iff (!aresetn)
        bit_take && closes_byte |=> m_valid)
        else $error("closed byte did not reach the result register");

    // reset leaves the packer empty
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid && pos_reg == 3'd0)
        else $error("packer not empty after reset");

endmodule
